[rtl/clock_time_set_editor_assert.svh]
// Assertion macros used by the top level of the clock time setting editor.
`ifndef CLOCK_TIME_SET_EDITOR_ASSERT_SVH
`define CLOCK_TIME_SET_EDITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define CTS_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define CTS_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/cts_pkg.sv]
// Package with the types, codes and helper functions of the clock time setting editor.
`timescale 1ns / 1ps

package cts_pkg;

  localparam logic [3:0] KEY_OK     = 4'd10;
  localparam logic [3:0] KEY_ABORT  = 4'd11;
  localparam logic [3:0] KEY_LEFT   = 4'd12;
  localparam logic [3:0] KEY_RIGHT  = 4'd13;
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

  localparam logic KIND_SNAPSHOT = 1'b0;
  localparam logic KIND_KEY      = 1'b1;

  localparam logic [2:0] FOC_YEAR   = 3'd0;
  localparam logic [2:0] FOC_MONTH  = 3'd1;
  localparam logic [2:0] FOC_DAY    = 3'd2;
  localparam logic [2:0] FOC_HOUR   = 3'd3;
  localparam logic [2:0] FOC_MINUTE = 3'd4;
  localparam logic [2:0] FOC_SECOND = 3'd5;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic       kind;
    logic [3:0] key_code;
    logic       rtc_ready;
    logic [15:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } in_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } time_t;

  typedef struct packed {
    time_t tm;
    logic  leap;
  } snap_t;

  typedef struct packed {
    time_t      tm;
    logic       editing;
    logic [2:0] focus;
    logic       commit;
  } res_t;

  // A nibble above nine counts as nine.
  function automatic logic [3:0] bcd_clamp(input logic [3:0] nib);
    return (nib > 4'd9) ? 4'd9 : nib;
  endfunction

  function automatic logic [6:0] bcd_pair(input logic [3:0] hi, input logic [3:0] lo);
    return 7'({3'b000, bcd_clamp(hi)} * 7'd10) + 7'(bcd_clamp(lo));
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                         len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/cts_bcd_conv.sv]
// BCD snapshot converter: binary calendar time, saturated, with the leap-year flag.
`timescale 1ns / 1ps

module cts_bcd_conv (
  input  cts_pkg::in_item_t item,
  output cts_pkg::snap_t    snap
);

  logic [6:0]  year_hi;
  logic [6:0]  year_lo;
  logic [6:0]  month_bin;
  logic [6:0]  day_bin;
  logic [3:0]  wday_bin;
  logic [6:0]  hour_bin;
  logic [6:0]  minute_bin;
  logic [6:0]  second_bin;

  assign year_hi    = cts_pkg::bcd_pair(item.year_bcd[15:12], item.year_bcd[11:8]);
  assign year_lo    = cts_pkg::bcd_pair(item.year_bcd[7:4], item.year_bcd[3:0]);
  assign month_bin  = cts_pkg::bcd_pair({3'b000, item.month_bcd[4]}, item.month_bcd[3:0]);
  assign day_bin    = cts_pkg::bcd_pair({2'b00, item.day_bcd[5:4]}, item.day_bcd[3:0]);
  assign wday_bin   = {1'b0, item.weekday_bcd};
  assign hour_bin   = cts_pkg::bcd_pair({2'b00, item.hour_bcd[5:4]}, item.hour_bcd[3:0]);
  assign minute_bin = cts_pkg::bcd_pair({1'b0, item.minute_bcd[6:4]}, item.minute_bcd[3:0]);
  assign second_bin = cts_pkg::bcd_pair({1'b0, item.second_bcd[6:4]}, item.second_bcd[3:0]);

  always_comb begin
    snap.tm.year    = 14'({7'd0, year_hi} * 14'd100) + 14'(year_lo);
    snap.tm.month   = (month_bin > 7'd12) ? 4'd12 : month_bin[3:0];
    snap.tm.day     = (day_bin > 7'd31) ? 5'd31 : day_bin[4:0];
    snap.tm.weekday = (wday_bin > 4'd6) ? 3'd6 : wday_bin[2:0];
    snap.tm.hour    = (hour_bin > 7'd23) ? 5'd23 : hour_bin[4:0];
    snap.tm.minute  = (minute_bin > 7'd59) ? 6'd59 : minute_bin[5:0];
    snap.tm.second  = (second_bin > 7'd59) ? 6'd59 : second_bin[5:0];
    // Divisible by four, and by four hundred when the low two digits are zero.
    snap.leap       = (year_lo == 7'd0) ? (year_hi[1:0] == 2'b00) : (year_lo[1:0] == 2'b00);
  end

endmodule

[rtl/cts_edit.sv]
// Editor state: held time, digit entry, focus and edit mode, updated once per transaction.
`timescale 1ns / 1ps

module cts_edit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  cts_pkg::in_item_t item,
  input  cts_pkg::snap_t    snap,
  output cts_pkg::res_t     res
);

  cts_pkg::time_t tm_r, tm_nxt;
  logic           leap_r, leap_nxt;
  logic [6:0]     entry_r, entry_nxt;
  logic [2:0]     focus_r, focus_nxt;
  logic           edit_r, edit_nxt;
  logic           commit_nxt;
  logic [9:0]     v_full;
  logic [9:0]     v_sel;
  logic [9:0]     digit;
  logic           restart;

  assign digit  = 10'(item.key_code);
  assign v_full = 10'({entry_r, 3'b000}) + 10'({entry_r, 1'b0}) + digit;

  always_comb begin
    case (focus_r)
      cts_pkg::FOC_YEAR:   restart = (v_full > 10'd99);
      cts_pkg::FOC_MONTH:  restart = (v_full == 10'd0) || (v_full > 10'd12);
      cts_pkg::FOC_DAY:    restart = (v_full > 10'(cts_pkg::month_len(leap_r, tm_r.month)));
      cts_pkg::FOC_HOUR:   restart = (v_full > 10'd23);
      cts_pkg::FOC_MINUTE: restart = (v_full > 10'd59);
      cts_pkg::FOC_SECOND: restart = (v_full > 10'd59);
      default:             restart = 1'b0;
    endcase
  end

  assign v_sel = restart ? digit : v_full;

  always_comb begin
    tm_nxt     = tm_r;
    leap_nxt   = leap_r;
    entry_nxt  = entry_r;
    focus_nxt  = focus_r;
    edit_nxt   = edit_r;
    commit_nxt = 1'b0;
    if (item.kind == cts_pkg::KIND_SNAPSHOT) begin
      if (item.rtc_ready && !edit_r) begin
        tm_nxt   = snap.tm;
        leap_nxt = snap.leap;
      end
    end else if (item.key_code <= cts_pkg::KEY_DIGIT_MAX) begin
      entry_nxt = v_sel[6:0];
      case (focus_r)
        cts_pkg::FOC_YEAR: begin
          tm_nxt.year = 14'(v_sel);
          leap_nxt    = (v_sel[1:0] == 2'b00);
        end
        cts_pkg::FOC_MONTH:  tm_nxt.month  = v_sel[3:0];
        cts_pkg::FOC_DAY:    tm_nxt.day    = v_sel[4:0];
        cts_pkg::FOC_HOUR:   tm_nxt.hour   = v_sel[4:0];
        cts_pkg::FOC_MINUTE: tm_nxt.minute = v_sel[5:0];
        cts_pkg::FOC_SECOND: tm_nxt.second = v_sel[5:0];
        default:             entry_nxt     = entry_r;
      endcase
    end else begin
      case (item.key_code)
        cts_pkg::KEY_OK: begin
          commit_nxt = 1'b1;
          entry_nxt  = 7'd0;
          edit_nxt   = !edit_r;
        end
        cts_pkg::KEY_ABORT: begin
          entry_nxt = 7'd0;
          edit_nxt  = !edit_r;
        end
        cts_pkg::KEY_LEFT: begin
          entry_nxt = 7'd0;
          focus_nxt = (focus_r == cts_pkg::FOC_YEAR || focus_r > cts_pkg::FOC_SECOND) ?
                      cts_pkg::FOC_SECOND : focus_r - 3'd1;
        end
        cts_pkg::KEY_RIGHT: begin
          entry_nxt = 7'd0;
          focus_nxt = (focus_r >= cts_pkg::FOC_SECOND) ? cts_pkg::FOC_YEAR : focus_r + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_r    <= '0;
      leap_r  <= 1'b1;
      entry_r <= 7'd0;
      focus_r <= cts_pkg::FOC_YEAR;
      edit_r  <= 1'b0;
    end else if (fire) begin
      tm_r    <= tm_nxt;
      leap_r  <= leap_nxt;
      entry_r <= entry_nxt;
      focus_r <= focus_nxt;
      edit_r  <= edit_nxt;
    end
  end

  assign res = '{tm: tm_nxt, editing: edit_nxt, focus: focus_nxt, commit: commit_nxt};

endmodule

[rtl/clock_time_set_editor.sv]
// Top level of the keypad time setting editor with its input and result registers.
`timescale 1ns / 1ps

// Each accepted transaction is either an RTC snapshot (tuser low) or a key event (tuser high)
// and yields exactly one result transaction showing the held time, edit mode, focus and the
// commit flag after the update. One transaction is accepted per clock cycle while the result
// channel can take results; the transaction is held in the input register, where the update
// logic reads it, and its result is then loaded into the result register. Throughput is set
// by the result channel only: while out_tready is held low the input register fills and
// in_tready drops. Snapshots are loaded only when the RTC is ready and the block is not in
// edit mode. No clearing pass.

`include "clock_time_set_editor_assert.svh"

module clock_time_set_editor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // key_code[3:0], rtc_ready[4], year_bcd[20:5], month_bcd[25:21], day_bcd[31:26],
  // weekday_bcd[34:32], hour_bcd[40:35], minute_bcd[47:41], second_bcd[54:48], zero[55]
  input  logic [cts_pkg::IN_TDATA_W-1:0]      in_tdata,
  // kind[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // year_out[13:0], month_out[17:14], day_out[22:18], weekday_out[25:23], hour_out[30:26],
  // minute_out[36:31], second_out[42:37], editing_out[43], focus_out[46:44], commit[47]
  output logic [cts_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  cts_pkg::in_item_t in_item;
  cts_pkg::in_item_t in_r;
  logic              in_valid_r;
  logic              out_valid_r;
  cts_pkg::res_t     out_r;
  cts_pkg::snap_t    snap;
  cts_pkg::res_t     res;
  logic              out_free;
  logic              fire;
  logic              ok_fire;

  always_comb begin
    in_item.kind        = in_tuser;
    in_item.key_code    = in_tdata[3:0];
    in_item.rtc_ready   = in_tdata[4];
    in_item.year_bcd    = in_tdata[20:5];
    in_item.month_bcd   = in_tdata[25:21];
    in_item.day_bcd     = in_tdata[31:26];
    in_item.weekday_bcd = in_tdata[34:32];
    in_item.hour_bcd    = in_tdata[40:35];
    in_item.minute_bcd  = in_tdata[47:41];
    in_item.second_bcd  = in_tdata[54:48];
  end

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = rst_n && (!in_valid_r || out_free);

  cts_bcd_conv u_conv (
    .item (in_r),
    .snap (snap)
  );

  cts_edit u_edit (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_r),
    .snap  (snap),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r <= in_item;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.commit, out_r.focus, out_r.editing, out_r.tm.second,
                       out_r.tm.minute, out_r.tm.hour, out_r.tm.weekday, out_r.tm.day,
                       out_r.tm.month, out_r.tm.year};

  assign ok_fire = fire && in_r.kind == cts_pkg::KIND_KEY && in_r.key_code == cts_pkg::KEY_OK;

  `CTS_ASSERT_IMP(a_focus_range, out_tvalid, out_tdata[46:44] <= 3'd5)
  `CTS_ASSERT_IMP(a_month_range, out_tvalid, out_tdata[17:14] <= 4'd12)
  `CTS_ASSERT_NXT(a_ok_commits, ok_fire, out_tvalid && out_tdata[47])

endmodule

[verif/clock_time_set_editor_tb.sv]
// Self-checking testbench for the keypad time setting editor on its transaction streams.
`timescale 1ns / 1ps

module clock_time_set_editor_tb;

  localparam logic [3:0] KEY_NONE   = 4'd14;
  localparam logic [3:0] KEY_UNUSED = 4'd15;
  localparam int LONG_HOLD   = 40;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic        pad;
    logic [6:0]  second_bcd;
    logic [6:0]  minute_bcd;
    logic [5:0]  hour_bcd;
    logic [2:0]  weekday_bcd;
    logic [5:0]  day_bcd;
    logic [4:0]  month_bcd;
    logic [15:0] year_bcd;
    logic        rtc_ready;
    logic [3:0]  key_code;
  } key_snap_t;

  typedef struct packed {
    logic        commit;
    logic [2:0]  focus;
    logic        editing;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } readout_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [cts_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cts_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic           ed_editing = 1'b0;
  logic [2:0]     ed_focus = cts_pkg::FOC_YEAR;
  logic [6:0]     ed_entry = '0;
  cts_pkg::time_t held = '0;

  readout_t awaited_readouts[$];
  int       errors = 0;
  int       items_sent = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     hold_req = 1'b0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  clock_time_set_editor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int bcd_value(input logic [15:0] raw, input int digits, input int ceiling);
    int acc;
    int nib;
    acc = 0;
    for (int i = digits - 1; i >= 0; i--) begin
      nib = int'((raw >> (4 * i)) & 16'hF);
      if (nib > 9) nib = 9;
      acc = acc * 10 + nib;
    end
    return (acc > ceiling) ? ceiling : acc;
  endfunction

  function automatic int days_in_month(input int yr, input int mon);
    case (mon)
      2: return ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic void enter_digit(input int digit);
    int v;
    v = int'(ed_entry) * 10 + digit;
    case (ed_focus)
      cts_pkg::FOC_YEAR: begin
        if (v > 99) v = digit;
        held.year = 14'(v);
      end
      cts_pkg::FOC_MONTH: begin
        if (v < 1 || v > 12) v = digit;
        held.month = 4'(v);
      end
      cts_pkg::FOC_DAY: begin
        if (v > days_in_month(int'(held.year), int'(held.month))) v = digit;
        held.day = 5'(v);
      end
      cts_pkg::FOC_HOUR: begin
        if (v > 23) v = digit;
        held.hour = 5'(v);
      end
      cts_pkg::FOC_MINUTE: begin
        if (v > 59) v = digit;
        held.minute = 6'(v);
      end
      cts_pkg::FOC_SECOND: begin
        if (v > 59) v = digit;
        held.second = 6'(v);
      end
      default: return;
    endcase
    ed_entry = 7'(v);
  endfunction

  function automatic readout_t advance_editor(input logic kind, input key_snap_t d);
    readout_t r;
    logic     commit_flag;
    commit_flag = 1'b0;
    if (kind == cts_pkg::KIND_SNAPSHOT) begin
      if (d.rtc_ready && !ed_editing) begin
        held.year    = 14'(bcd_value(d.year_bcd, 4, 9999));
        held.month   = 4'(bcd_value(16'(d.month_bcd), 2, 12));
        held.day     = 5'(bcd_value(16'(d.day_bcd), 2, 31));
        held.weekday = 3'(bcd_value(16'(d.weekday_bcd), 1, 6));
        held.hour    = 5'(bcd_value(16'(d.hour_bcd), 2, 23));
        held.minute  = 6'(bcd_value(16'(d.minute_bcd), 2, 59));
        held.second  = 6'(bcd_value(16'(d.second_bcd), 2, 59));
      end
    end else if (d.key_code <= cts_pkg::KEY_DIGIT_MAX) begin
      enter_digit(int'(d.key_code));
    end else if (d.key_code == cts_pkg::KEY_OK) begin
      commit_flag = 1'b1;
      ed_entry = '0;
      ed_editing = !ed_editing;
    end else if (d.key_code == cts_pkg::KEY_ABORT) begin
      ed_entry = '0;
      ed_editing = !ed_editing;
    end else if (d.key_code == cts_pkg::KEY_LEFT) begin
      ed_entry = '0;
      ed_focus = (ed_focus == cts_pkg::FOC_YEAR || ed_focus > cts_pkg::FOC_SECOND) ?
                 cts_pkg::FOC_SECOND : 3'(ed_focus - 1);
    end else if (d.key_code == cts_pkg::KEY_RIGHT) begin
      ed_entry = '0;
      ed_focus = (ed_focus >= cts_pkg::FOC_SECOND) ? cts_pkg::FOC_YEAR : 3'(ed_focus + 1);
    end
    r.year    = held.year;
    r.month   = held.month;
    r.day     = held.day;
    r.weekday = held.weekday;
    r.hour    = held.hour;
    r.minute  = held.minute;
    r.second  = held.second;
    r.editing = ed_editing;
    r.focus   = ed_focus;
    r.commit  = commit_flag;
    return r;
  endfunction

  task automatic send_item(input logic kind, input key_snap_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    awaited_readouts.push_back(advance_editor(kind, d));
    if (!(kind == cts_pkg::KIND_KEY && d.key_code >= KEY_NONE)) items_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (awaited_readouts.size() != 0) @(posedge clk);
  endtask

  function automatic key_snap_t key_item(input logic [3:0] code);
    key_snap_t   d;
    logic [55:0] raw;
    raw = 56'({$urandom, $urandom});
    d = raw;
    d.key_code = code;
    d.pad = 1'b0;
    return d;
  endfunction

  function automatic logic [7:0] bcd2(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  task automatic press(input logic [3:0] code);
    send_item(cts_pkg::KIND_KEY, key_item(code));
  endtask

  task automatic snap(input logic ready, input logic [15:0] yr, input logic [4:0] mon,
                      input logic [5:0] dy, input logic [2:0] wd, input logic [5:0] hr,
                      input logic [6:0] mi, input logic [6:0] se);
    key_snap_t d;
    d = key_item(4'($urandom_range(15)));
    d.rtc_ready   = ready;
    d.year_bcd    = yr;
    d.month_bcd   = mon;
    d.day_bcd     = dy;
    d.weekday_bcd = wd;
    d.hour_bcd    = hr;
    d.minute_bcd  = mi;
    d.second_bcd  = se;
    send_item(cts_pkg::KIND_SNAPSHOT, d);
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(9) < 7)
        snap($urandom_range(9) != 0,
             {bcd2($urandom_range(99)), bcd2($urandom_range(99))},
             5'(bcd2($urandom_range(1, 12))), 6'(bcd2($urandom_range(1, 31))),
             3'($urandom_range(6)), 6'(bcd2($urandom_range(23))),
             7'(bcd2($urandom_range(59))), 7'(bcd2($urandom_range(59))));
      else
        send_item(cts_pkg::KIND_SNAPSHOT, key_item(4'($urandom_range(15))));
    end else if (pick < 70) begin
      press(4'($urandom_range(9)));
    end else if (pick < 82) begin
      press(pick[0] ? cts_pkg::KEY_LEFT : cts_pkg::KEY_RIGHT);
    end else if (pick < 92) begin
      press(pick[0] ? cts_pkg::KEY_OK : cts_pkg::KEY_ABORT);
    end else begin
      press(4'($urandom_range(14, 15)));
    end
  endtask

  // A typical session: toggle edit mode, move to a few fields, type into each, then toggle it back.
  task automatic run_edit_session();
    press($urandom_range(3) != 0 ? cts_pkg::KEY_OK : cts_pkg::KEY_ABORT);
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 3))
        press($urandom_range(1) ? cts_pkg::KEY_LEFT : cts_pkg::KEY_RIGHT);
      repeat ($urandom_range(1, 3)) press(4'($urandom_range(9)));
    end
    press($urandom_range(3) != 0 ? cts_pkg::KEY_OK : cts_pkg::KEY_ABORT);
  endtask

  task automatic test_snapshot_loading();
    snap(1'b1, 16'h2024, 5'h02, 6'h29, 3'd4, 6'h23, 7'h59, 7'h59);
    snap(1'b0, 16'h1999, 5'h11, 6'h15, 3'd1, 6'h10, 7'h20, 7'h30);
    snap(1'b1, 16'hFFFF, 5'h1F, 6'h3F, 3'h7, 6'h3F, 7'h7F, 7'h7F);
    snap(1'b1, 16'h0000, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 7'h00);
    snap(1'b1, 16'h1A3B, 5'h0C, 6'h1F, 3'd5, 6'h0F, 7'h4E, 7'h5A);
    wait_for_results();
  endtask

  task automatic test_key_editing();
    press(KEY_NONE);
    press(KEY_UNUSED);
    press(4'd9);
    press(4'd9);
    press(4'd7);
    press(cts_pkg::KEY_RIGHT);
    press(4'd0);
    press(4'd1);
    press(4'd2);
    press(cts_pkg::KEY_RIGHT);
    press(cts_pkg::KEY_LEFT);
    press(4'd2);
    press(cts_pkg::KEY_RIGHT);
    press(4'd2);
    press(4'd9);
    press(cts_pkg::KEY_OK);
    snap(1'b1, 16'h2000, 5'h02, 6'h29, 3'd2, 6'h12, 7'h34, 7'h56);
    press(cts_pkg::KEY_ABORT);
    press(cts_pkg::KEY_LEFT);
    press(cts_pkg::KEY_LEFT);
    press(cts_pkg::KEY_LEFT);
    press(cts_pkg::KEY_RIGHT);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 30) run_edit_session();
      else send_random_item();
    end
    wait_for_results();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (30) send_random_item();
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= LONG_HOLD;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    readout_t got;
    readout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (awaited_readouts.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", out_tdata);
        errors++;
      end else begin
        want = awaited_readouts.pop_front();
        check_field("year_out", int'(want.year), int'(got.year));
        check_field("month_out", int'(want.month), int'(got.month));
        check_field("day_out", int'(want.day), int'(got.day));
        check_field("weekday_out", int'(want.weekday), int'(got.weekday));
        check_field("hour_out", int'(want.hour), int'(got.hour));
        check_field("minute_out", int'(want.minute), int'(got.minute));
        check_field("second_out", int'(want.second), int'(got.second));
        check_field("editing_out", int'(want.editing), int'(got.editing));
        check_field("focus_out", int'(want.focus), int'(got.focus));
        check_field("commit", int'(want.commit), int'(got.commit));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_snapshot_loading();
    test_key_editing();
    test_random_traffic(270, 10, 81);
    test_output_stall();
    test_random_traffic(270, 81, 10);
    test_random_traffic(270, 0, 0);
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_bcd_conv.sv
rtl/cts_edit.sv
rtl/clock_time_set_editor.sv
verif/clock_time_set_editor_tb.sv
